// ===== sv/bcc_pkg.sv =====
// Shared constants for the button click classifier.
// Register indexes, reset values and default counter widths; no dependencies.
package bcc_pkg;

  localparam int TICK_COUNT_BITS_DEF  = 16;
  localparam int CLICK_COUNT_BITS_DEF = 3;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t CFG_ACTIVE_HIGH  = 2'd0;
  localparam cfg_index_t CFG_DEBOUNCE     = 2'd1;
  localparam cfg_index_t CFG_LONG_PRESS   = 2'd2;
  localparam cfg_index_t CFG_DOUBLE_CLICK = 2'd3;

  localparam logic      ACTIVE_HIGH_RST  = 1'b0;
  localparam cfg_data_t DEBOUNCE_RST     = 16'd20;
  localparam cfg_data_t LONG_PRESS_RST   = 16'd700;
  localparam cfg_data_t DOUBLE_CLICK_RST = 16'd300;

endpackage

// ===== sv/button_click_classifier_top.sv =====
// Button click classifier: debounce, click / double-click / long-press flags.
// An accepted item goes through the input register, then the state update into
// the result register. Throughput: one item per cycle unless stalled by out_ready,
// set by the combinational counter update and compare. rst_n is synchronous:
// it clears the pipeline valids and all classifier state (released, no flags) and
// restores the register defaults. Depends on bcc_pkg.
module button_click_classifier_top #(
  parameter int TICK_COUNT_BITS  = bcc_pkg::TICK_COUNT_BITS_DEF,
  parameter int CLICK_COUNT_BITS = bcc_pkg::CLICK_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_raw_level,
  input  logic                in_take_click,
  input  logic                in_take_double,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_pressed_now,
  output logic                out_click_pending,
  output logic                out_double_pending,
  output logic                out_long_press,
  input  logic                cfg_we,
  input  bcc_pkg::cfg_index_t cfg_index,
  input  bcc_pkg::cfg_data_t  cfg_data
);

  localparam int CMP_W = (TICK_COUNT_BITS > bcc_pkg::CFG_DATA_W) ?
                         TICK_COUNT_BITS : bcc_pkg::CFG_DATA_W;

  typedef logic [TICK_COUNT_BITS-1:0]  tick_t;
  typedef logic [CLICK_COUNT_BITS-1:0] click_t;
  typedef logic [CMP_W-1:0]            cmp_t;

  localparam tick_t  TICK_MAX  = '1;
  localparam click_t CLICK_MAX = '1;
  localparam click_t CLICK_ONE = click_t'(1);

  function automatic tick_t bump(input tick_t v);
    return (v == TICK_MAX) ? TICK_MAX : v + tick_t'(1);
  endfunction

  // configuration
  logic               active_high_r;
  bcc_pkg::cfg_data_t debounce_r, long_press_r, double_click_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r  <= bcc_pkg::ACTIVE_HIGH_RST;
      debounce_r     <= bcc_pkg::DEBOUNCE_RST;
      long_press_r   <= bcc_pkg::LONG_PRESS_RST;
      double_click_r <= bcc_pkg::DOUBLE_CLICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::CFG_ACTIVE_HIGH:  active_high_r  <= cfg_data[0];
        bcc_pkg::CFG_DEBOUNCE:     debounce_r     <= cfg_data;
        bcc_pkg::CFG_LONG_PRESS:   long_press_r   <= cfg_data;
        bcc_pkg::CFG_DOUBLE_CLICK: double_click_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r, out_valid_r;
  logic out_free, s1_adv, in_acc;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = rst_n && (!s1_valid_r || out_free);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)      s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // input register
  logic lvl_r, take_click_r, take_double_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lvl_r         <= in_raw_level;
      take_click_r  <= in_take_click;
      take_double_r <= in_take_double;
    end
  end

  // classifier state
  logic   prior_r, settled_r, single_r, double_r, long_r;
  tick_t  steady_r, hold_r, gap_r;
  click_t clicks_r;

  logic   prior_nxt, settled_nxt, single_nxt, double_nxt, long_nxt;
  tick_t  steady_nxt, hold_nxt, gap_nxt;
  click_t clicks_nxt;
  logic   pressed, take_edge;

  always_comb begin
    pressed     = active_high_r ? lvl_r : !lvl_r;
    single_nxt  = single_r && !take_click_r;
    double_nxt  = double_r && !take_double_r;
    long_nxt    = long_r;
    settled_nxt = settled_r;
    clicks_nxt  = clicks_r;
    hold_nxt    = bump(hold_r);
    gap_nxt     = bump(gap_r);
    steady_nxt  = (pressed != prior_r) ? '0 : bump(steady_r);

    take_edge = (cmp_t'(steady_nxt) > cmp_t'(debounce_r)) && (pressed != settled_r);
    if (take_edge) begin
      settled_nxt = pressed;
      if (pressed) begin
        hold_nxt = '0;
        long_nxt = 1'b0;
      end else begin
        if (clicks_r != CLICK_MAX) clicks_nxt = clicks_r + CLICK_ONE;
        gap_nxt = '0;
      end
    end

    if (settled_nxt && !long_nxt && (cmp_t'(hold_nxt) > cmp_t'(long_press_r)))
      long_nxt = 1'b1;

    // close the click group once the gap has run out
    if ((clicks_nxt != '0) && (cmp_t'(gap_nxt) > cmp_t'(double_click_r))) begin
      if (clicks_nxt == CLICK_ONE) single_nxt = 1'b1;
      else                         double_nxt = 1'b1;
      clicks_nxt = '0;
    end

    prior_nxt = pressed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r   <= 1'b0;
      settled_r <= 1'b0;
      single_r  <= 1'b0;
      double_r  <= 1'b0;
      long_r    <= 1'b0;
      steady_r  <= '0;
      hold_r    <= '0;
      gap_r     <= '0;
      clicks_r  <= '0;
    end else if (s1_adv) begin
      prior_r   <= prior_nxt;
      settled_r <= settled_nxt;
      single_r  <= single_nxt;
      double_r  <= double_nxt;
      long_r    <= long_nxt;
      steady_r  <= steady_nxt;
      hold_r    <= hold_nxt;
      gap_r     <= gap_nxt;
      clicks_r  <= clicks_nxt;
    end
  end

  // result register
  logic pressed_out_r, click_out_r, double_out_r, long_out_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pressed_out_r <= settled_nxt;
      click_out_r   <= single_nxt;
      double_out_r  <= double_nxt;
      long_out_r    <= long_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pressed_now    = pressed_out_r;
  assign out_click_pending  = click_out_r;
  assign out_double_pending = double_out_r;
  assign out_long_press     = long_out_r;

endmodule

// ===== sv/bcc_checker.sv =====
// Port-level checks for button_click_classifier_top, attached by bind.
// Watches the handshake and result ports only; no package dependencies.
module bcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_pressed_now,
  input logic out_click_pending,
  input logic out_double_pending,
  input logic out_long_press
);

  // long-press flag of the last delivered item
  logic last_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                      last_long_r <= 1'b0;
    else if (out_valid && out_ready) last_long_r <= out_long_press;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressed_now) &&
      $stable(out_click_pending) && $stable(out_double_pending) && $stable(out_long_press))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the result side free");

  // long press is raised or dropped only on a tick with the button held
  a_long_changes_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_long_press != last_long_r) |-> out_pressed_now)
    else $error("long press changed while released");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (.*);
